[src/kts_pkg.sv]
// ============================================================================
// kts_pkg
// Shared types, sizes, codes and helpers for the keyed table stream cipher.
// ============================================================================
`default_nettype none

package kts_pkg;

    // Sizing
    localparam int WORDS_PER_BLOCK = 16;
    localparam int MAX_KEY_BYTES   = 64;
    localparam int TABLE_DEPTH     = 256;
    localparam int STACK_DEPTH     = 48;
    localparam int STACK_SLOTS     = 16;
    localparam int SEEK_PUSHES     = 16;

    localparam int KA_W  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KC_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam int WA_W  = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
    localparam int WC_W  = $clog2(WORDS_PER_BLOCK + 1);
    localparam int BP_W  = WA_W + 2;
    localparam int BYTES_PER_BLOCK = 4 * WORDS_PER_BLOCK;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_CRYPT = 1'b1;

    // Status codes
    localparam logic [1:0] ST_KEY_TAKEN = 2'd0;
    localparam logic [1:0] ST_KEYED     = 2'd1;
    localparam logic [1:0] ST_CRYPTED   = 2'd2;
    localparam logic [1:0] ST_NOT_KEYED = 2'd3;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
    } res_item_t;

    function automatic logic [31:0] rot8(input logic [31:0] v);
        rot8 = {v[23:0], v[31:24]};
    endfunction

    function automatic logic [31:0] rot24(input logic [31:0] v);
        rot24 = {v[7:0], v[31:8]};
    endfunction

endpackage

`default_nettype wire

[src/keyed_table_stream_cipher_top.sv]
// ============================================================================
// keyed_table_stream_cipher_top
// Stream cipher with a keyed 256-word mixing table and a history-stack
// keystream generator.
// ============================================================================
//  channel  | dir | tdata          | tuser            | tlast
//  ---------+-----+----------------+------------------+-----------------
//  s_axis   | in  | [7:0] data_in  | [0] command      | last key byte
//  m_axis   | out | [7:0] data_out | [1:0] status     | -
//
//  One item at a time. A key byte load or an unkeyed crypt goes from idle
//  straight to its result; a crypt from a filled buffer first reads the keystream word.
//  The last key byte runs the schedule through the single table memory.
//  A buffer refill runs generator pushes and pops, once every 63
//  crypted bytes and on the first crypt after keying.
//  Reset clears control state only; memories are written before being read.
//  A result waits in the output register while the next item is taken.
// ============================================================================
`default_nettype none

module keyed_table_stream_cipher_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_in
    input  wire logic [0:0] s_tuser,   // [0] command
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] data_out
    output logic [1:0]      m_tuser    // [1:0] status
);
    import kts_pkg::*;

    in_item_t   in_item;
    res_item_t  res;
    logic       res_load;
    logic       res_free;
    logic       m_tvalid_reg, m_tvalid_next;
    res_item_t  out_reg, out_next;

    assign in_item  = '{cmd: s_tuser[0], data: s_tdata, last: s_tlast};
    assign res_free = !m_tvalid_reg || m_tready;

    kts_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .res_free (res_free),
        .res_load (res_load),
        .res      (res)
    );

    // Output register: load on a free slot, drop valid once taken
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_load)
        begin
            m_tvalid_next = 1'b1;
            out_next      = res;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.status;

endmodule

`default_nettype wire

[src/kts_ram.sv]
// ============================================================================
// kts_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
`default_nettype none

module kts_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/kts_core.sv]
// ============================================================================
// kts_core
// Sequencer: key store, table schedule, history-stack generator and crypt.
// ============================================================================
`default_nettype none

module kts_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire kts_pkg::in_item_t     in_item,
    input  wire logic                  res_free,
    output logic                       res_load,
    output kts_pkg::res_item_t         res
);
    import kts_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_R0     = 11'b000_0000_0010,
        S_SHIFT  = 11'b000_0000_0100,
        S_SWAP   = 11'b000_0000_1000,
        S_XOR    = 11'b000_0001_0000,
        S_SEEK   = 11'b000_0010_0000,
        S_REFILL = 11'b000_0100_0000,
        S_GEN    = 11'b000_1000_0000,
        S_CRYPT  = 11'b001_0000_0000,
        S_DONE   = 11'b010_0000_0000,
        S_SPARE  = 11'b100_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         ph_reg, ph_next;
    logic [7:0]         k_reg, k_next;
    logic [KA_W-1:0]    kpos_reg, kpos_next;
    logic [1:0]         rnd_reg, rnd_next;
    logic               pass_reg, pass_next;
    logic [7:0]         idx_reg, idx_next;
    logic [31:0]        tk_reg, tk_next;
    logic [31:0]        a_reg, a_next;
    logic [31:0]        b_reg, b_next;
    logic [31:0]        sw_reg, sw_next;
    logic [31:0]        tmp_reg, tmp_next;
    logic [31:0]        hb_reg, hb_next;
    logic [4:0]         depth_reg, depth_next;
    logic [3:0]         e_reg, e_next;
    logic [3:0]         gstep_reg, gstep_next;
    logic               gpop_reg, gpop_next;
    logic               seek_reg, seek_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [WC_W-1:0]    w_reg, w_next;
    logic [BP_W-1:0]    bp_reg, bp_next;
    logic               bv_reg, bv_next;
    logic               keyed_reg, keyed_next;
    logic [KC_W-1:0]    kc_reg, kc_next;
    res_item_t          res_reg, res_next;

    // Memory ports
    logic               tab_we;
    logic [7:0]         tab_waddr, tab_raddr;
    logic [31:0]        tab_wdata, tab_rdata;
    logic               key_we;
    logic [KA_W-1:0]    key_waddr, key_raddr;
    logic [7:0]         key_rdata;
    logic               stk_we;
    logic [5:0]         stk_waddr, stk_raddr;
    logic [31:0]        stk_wdata, stk_rdata;
    logic               ks_we;
    logic [WA_W-1:0]    ks_waddr, ks_raddr;
    logic [31:0]        ks_wdata, ks_rdata;

    logic [KC_W-1:0]    key_len;
    logic [KC_W-1:0]    kpos_inc;
    logic [7:0]         idx_new;
    logic [4:0]         depth_dec;
    logic [31:0]        ks_word_sh;

    kts_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(32)) u_table (
        .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
        .raddr(tab_raddr), .rdata(tab_rdata)
    );

    kts_ram #(.DEPTH(MAX_KEY_BYTES), .WIDTH(8)) u_key (
        .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(in_item.data),
        .raddr(key_raddr), .rdata(key_rdata)
    );

    kts_ram #(.DEPTH(STACK_DEPTH), .WIDTH(32)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    kts_ram #(.DEPTH(WORDS_PER_BLOCK), .WIDTH(32)) u_ks (
        .clk(clk), .we(ks_we), .waddr(ks_waddr), .wdata(ks_wdata),
        .raddr(ks_raddr), .rdata(ks_rdata)
    );

    assign key_len    = (kc_reg == '0) ? KC_W'(1) : kc_reg;
    assign kpos_inc   = KC_W'(kpos_reg) + KC_W'(1);
    assign idx_new    = tab_rdata[7:0] + key_rdata + idx_reg;
    assign depth_dec  = (depth_reg != '0) ? depth_reg - 5'd1 : 5'd0;
    assign ks_word_sh = ks_rdata >> {bp_reg[1:0], 3'b000};

    assign in_ready = (state_reg == S_IDLE);
    assign res      = res_reg;

    // Next-state and datapath sequencing
    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        k_next     = k_reg;
        kpos_next  = kpos_reg;
        rnd_next   = rnd_reg;
        pass_next  = pass_reg;
        idx_next   = idx_reg;
        tk_next    = tk_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        sw_next    = sw_reg;
        tmp_next   = tmp_reg;
        hb_next    = hb_reg;
        depth_next = depth_reg;
        e_next     = e_reg;
        gstep_next = gstep_reg;
        gpop_next  = gpop_reg;
        seek_next  = seek_reg;
        cnt_next   = cnt_reg;
        w_next     = w_reg;
        bp_next    = bp_reg;
        bv_next    = bv_reg;
        keyed_next = keyed_reg;
        kc_next    = kc_reg;
        res_next   = res_reg;
        res_load   = 1'b0;

        tab_we     = 1'b0;
        tab_waddr  = k_reg;
        tab_wdata  = '0;
        tab_raddr  = k_reg;
        key_we     = 1'b0;
        key_waddr  = kc_reg[KA_W-1:0];
        key_raddr  = kpos_reg;
        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_wdata  = '0;
        stk_raddr  = '0;
        ks_we      = 1'b0;
        ks_waddr   = w_reg[WA_W-1:0];
        ks_wdata   = b_reg ^ a_reg;
        ks_raddr   = bp_reg[BP_W-1:2];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.cmd == CMD_LOAD)
                    begin
                        // store the key byte unless the store is full
                        if (kc_reg < KC_W'(MAX_KEY_BYTES))
                        begin
                            key_we  = 1'b1;
                            kc_next = kc_reg + KC_W'(1);
                        end
                        if (in_item.last)
                        begin
                            k_next     = '0;
                            state_next = S_R0;
                        end
                        else
                        begin
                            res_next   = '{data: 8'd0, status: ST_KEY_TAKEN};
                            state_next = S_DONE;
                        end
                    end
                    else if (!keyed_reg)
                    begin
                        res_next   = '{data: in_item.data, status: ST_NOT_KEYED};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        res_next.data = in_item.data;
                        ph_next       = '0;
                        if (!bv_reg || (bp_reg >= BP_W'(BYTES_PER_BLOCK - 1)))
                        begin
                            w_next     = '0;
                            seek_next  = 1'b0;
                            state_next = S_REFILL;
                        end
                        else
                        begin
                            state_next = S_CRYPT;
                        end
                    end
                end
            end

            // first round: the shifted zero table is just the index
            S_R0:
            begin
                tab_we    = 1'b1;
                tab_wdata = {24'd0, k_reg};
                k_next    = k_reg + 8'd1;
                if (k_reg == 8'hff)
                begin
                    rnd_next   = '0;
                    pass_next  = 1'b0;
                    kpos_next  = '0;
                    idx_next   = 8'd0;
                    ph_next    = '0;
                    state_next = S_SWAP;
                end
            end

            // shift each word left a byte and add its index
            S_SHIFT:
            begin
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else
                begin
                    tab_we    = 1'b1;
                    tab_wdata = {tab_rdata[23:0], 8'd0} + {24'd0, k_reg};
                    k_next    = k_reg + 8'd1;
                    ph_next   = 2'd0;
                    if (k_reg == 8'hff)
                    begin
                        pass_next  = 1'b0;
                        kpos_next  = '0;
                        idx_next   = {6'd0, rnd_reg};
                        state_next = S_SWAP;
                    end
                end
            end

            // key-driven swap of entry k with entry idx
            S_SWAP:
            begin
                case (ph_reg)
                    2'd0:
                    begin
                        ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        idx_next  = idx_new;
                        tk_next   = tab_rdata;
                        tab_raddr = idx_new;
                        ph_next   = 2'd2;
                    end
                    2'd2:
                    begin
                        tab_we    = 1'b1;
                        tab_wdata = tab_rdata;
                        ph_next   = 2'd3;
                    end
                    default:
                    begin
                        tab_we    = 1'b1;
                        tab_waddr = idx_reg;
                        tab_wdata = tk_reg;
                        k_next    = k_reg + 8'd1;
                        kpos_next = (kpos_inc == key_len) ? '0 : kpos_inc[KA_W-1:0];
                        ph_next   = 2'd0;
                        if (k_reg == 8'hff)
                        begin
                            kpos_next = '0;
                            if (!pass_reg)
                            begin
                                pass_next = 1'b1;
                            end
                            else if (rnd_reg == 2'd3)
                            begin
                                state_next = S_XOR;
                            end
                            else
                            begin
                                rnd_next   = rnd_reg + 2'd1;
                                state_next = S_SHIFT;
                            end
                        end
                    end
                endcase
            end

            // fold the index into every word, then start the seek
            S_XOR:
            begin
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else
                begin
                    tab_we    = 1'b1;
                    tab_wdata = tab_rdata ^ {24'd0, k_reg};
                    k_next    = k_reg + 8'd1;
                    ph_next   = 2'd0;
                    if (k_reg == 8'hff)
                    begin
                        a_next     = '0;
                        b_next     = '0;
                        sw_next    = 32'd1;
                        depth_next = '0;
                        cnt_next   = '0;
                        seek_next  = 1'b1;
                        state_next = S_SEEK;
                    end
                end
            end

            S_SEEK:
            begin
                if (cnt_reg == 5'(SEEK_PUSHES))
                begin
                    kc_next    = '0;
                    keyed_next = 1'b1;
                    bv_next    = 1'b0;
                    bp_next    = '0;
                    res_next   = '{data: 8'd0, status: ST_KEYED};
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 5'd1;
                    gstep_next = '0;
                    gpop_next  = 1'b0;
                    state_next = S_GEN;
                end
            end

            // push until the weight is large, then emit a word and pop
            S_REFILL:
            begin
                gstep_next = '0;
                if (w_reg == WC_W'(WORDS_PER_BLOCK))
                begin
                    bv_next    = 1'b1;
                    bp_next    = '0;
                    ph_next    = '0;
                    state_next = S_CRYPT;
                end
                else if (sw_reg[31:16] == 16'd0)
                begin
                    gpop_next  = 1'b0;
                    state_next = S_GEN;
                end
                else
                begin
                    ks_we      = 1'b1;
                    w_next     = w_reg + WC_W'(1);
                    gpop_next  = 1'b1;
                    state_next = S_GEN;
                end
            end

            // generator step: a push or a pop, stepping through table and stack accesses
            S_GEN:
            begin
                gstep_next = gstep_reg + 4'd1;
                if (!gpop_reg)
                begin
                    case (gstep_reg)
                        4'd0: a_next = a_reg + sw_reg;
                        4'd1: b_next = b_reg + a_reg;
                        4'd2: a_next = a_reg + b_reg;
                        4'd3:
                        begin
                            stk_we    = (depth_reg < 5'(STACK_SLOTS));
                            stk_waddr = {2'd0, depth_reg[3:0]};
                            stk_wdata = a_reg;
                        end
                        4'd4:
                        begin
                            stk_we    = (depth_reg < 5'(STACK_SLOTS));
                            stk_waddr = {2'd1, depth_reg[3:0]};
                            stk_wdata = b_reg;
                        end
                        4'd5:
                        begin
                            stk_we    = (depth_reg < 5'(STACK_SLOTS));
                            stk_waddr = {2'd2, depth_reg[3:0]};
                            stk_wdata = sw_reg;
                            if (depth_reg < 5'(STACK_SLOTS))
                            begin
                                depth_next = depth_reg + 5'd1;
                            end
                            tab_raddr = b_reg[15:8];
                        end
                        4'd6:
                        begin
                            b_next    = rot24(tab_rdata ^ rot24(b_reg));
                            tab_raddr = a_reg[7:0];
                        end
                        4'd7:
                        begin
                            tmp_next  = rot8(tab_rdata ^ a_reg);
                            tab_raddr = b_reg[7:0];
                        end
                        4'd8:
                        begin
                            b_next    = b_reg ^ tab_rdata;
                            tab_raddr = tmp_reg[7:0];
                        end
                        default:
                        begin
                            a_next     = rot8(tab_rdata ^ tmp_reg);
                            sw_next    = {sw_reg[30:0], 1'b0};
                            state_next = seek_reg ? S_SEEK : S_REFILL;
                        end
                    endcase
                end
                else
                begin
                    case (gstep_reg)
                        4'd0:
                        begin
                            depth_next = depth_dec;
                            e_next     = depth_dec[3:0];
                            stk_raddr  = {2'd0, depth_dec[3:0]};
                        end
                        4'd1:
                        begin
                            tmp_next  = rot24(~stk_rdata);
                            tab_raddr = ~stk_rdata[15:8];
                            stk_raddr = {2'd1, e_reg};
                        end
                        4'd2:
                        begin
                            a_next    = rot24(tab_rdata ^ tmp_reg);
                            hb_next   = stk_rdata;
                            tab_raddr = stk_rdata[7:0];
                            stk_raddr = {2'd2, e_reg};
                        end
                        4'd3:
                        begin
                            tmp_next  = rot8(tab_rdata ^ hb_reg);
                            sw_next   = {stk_rdata[30:0], 1'b1};
                            tab_raddr = a_reg[7:0];
                        end
                        4'd4:
                        begin
                            a_next    = a_reg ^ tab_rdata;
                            tab_raddr = tmp_reg[7:0];
                        end
                        default:
                        begin
                            b_next     = rot8(tab_rdata ^ tmp_reg);
                            state_next = S_REFILL;
                        end
                    endcase
                end
            end

            // fetch the keystream word and pick the byte
            S_CRYPT:
            begin
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else
                begin
                    res_next.data   = res_reg.data ^ ks_word_sh[7:0];
                    res_next.status = ST_CRYPTED;
                    bp_next         = bp_reg + BP_W'(1);
                    state_next      = S_DONE;
                end
            end

            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg    <= '0;
            gstep_reg <= '0;
            gpop_reg  <= 1'b0;
            seek_reg  <= 1'b0;
            depth_reg <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            sw_reg    <= '0;
            bp_reg    <= '0;
            bv_reg    <= 1'b0;
            keyed_reg <= 1'b0;
            kc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            gstep_reg <= gstep_next;
            gpop_reg  <= gpop_next;
            seek_reg  <= seek_next;
            depth_reg <= depth_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            sw_reg    <= sw_next;
            bp_reg    <= bp_next;
            bv_reg    <= bv_next;
            keyed_reg <= keyed_next;
            kc_reg    <= kc_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        kpos_reg <= kpos_next;
        rnd_reg  <= rnd_next;
        pass_reg <= pass_next;
        idx_reg  <= idx_next;
        tk_reg   <= tk_next;
        tmp_reg  <= tmp_next;
        hb_reg   <= hb_next;
        e_reg    <= e_next;
        cnt_reg  <= cnt_next;
        w_reg    <= w_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

[src/kts_checker.sv]
// ============================================================================
// kts_checker
// Port-level checks for the keyed table stream cipher.
// ============================================================================
`default_nettype none

module kts_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [7:0] s_tdata,
    input wire logic [0:0] s_tuser,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser
);
    import kts_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Key loads report a zero data byte
    a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_KEY_TAKEN || m_tuser == ST_KEYED) |-> m_tdata == 8'd0)
        else $error("key load result with nonzero data");

    // One item at a time: ready drops after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted back to back");

    // An offered item carries known fields
    a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> !$isunknown({s_tdata, s_tuser, s_tlast}))
        else $error("offered item with unknown fields");

endmodule

bind keyed_table_stream_cipher_top kts_checker u_kts_checker (.*);

`default_nettype wire
